// ===== design/bpa_pkg.sv =====
// Package: sizes, state and command codes for the buddy page allocator.
package bpa_pkg;
  localparam int UnitCount = 1024;
  localparam int PageShift = 12;
  localparam int PageW = 10;                // page index bits
  localparam int LinkW = 11;                // page index or null
  localparam int TopOrder = 10;
  localparam logic [LinkW-1:0] Nil = 11'd1024;
  localparam logic [3:0] OrdNone = 4'hF;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NOTALLOC = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_DECODE,
    S_FIND,
    S_SPLIT_RD,
    S_SPLIT_WAIT,
    S_SPLIT_UNL,
    S_PUSH_B,
    S_PUSH_N,
    S_TAKE_RD,
    S_TAKE_WAIT,
    S_TAKE_UNL,
    S_TAKE_FIN,
    S_FREE_RD,
    S_FREE_WAIT,
    S_FREE_BUD,
    S_FREE_BWAIT,
    S_FREE_UNL,
    S_FREE_PUSH,
    S_CHECK_RD,
    S_CHECK_WAIT,
    S_UNL_P,
    S_UNL_N,
    S_DONE
  } state_t;
endpackage

// ===== design/buddy_page_allocator.sv =====
// Top level: buddy page allocator with sequenced access to per-page stores.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------
//  command   | start in, busy out    | command, request_size, block_address
//  result    | done out (one cycle)  | status, result_address, is_allocated
//  config    | cfg_we in             | cfg_wdata (region_base)
//
// After reset a clearing pass walks the 1024 pages of the page stores, one
// page a cycle, with busy high. A transaction passes through a decode state
// and a closing state; an allocate scans the free lists, splits level by
// level and takes the block; a free looks the block up, merges level by
// level and pushes it; a check reads the page. done shows the cycle after the
// closing state, busy still high. The longest transaction is a one-page
// allocate when only the whole region is free: the single read port of the
// page stores sets it, stepped by one sequencer level by level.
// Results cannot be stalled: done marks the one valid cycle.
module buddy_page_allocator
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] request_size,
  input  logic [47:0] block_address,
  input  logic        cfg_we,
  input  logic [47:0] cfg_wdata,
  output logic        done,
  output logic [1:0]  status,
  output logic [47:0] result_address,
  output logic        is_allocated
);

  // Page stores: one memory per field, each read at one address with
  // registered data, written at one address.
  logic [LinkW-1:0] next_mem [UnitCount];
  logic [LinkW-1:0] prev_mem [UnitCount];
  logic [3:0]       aord_mem [UnitCount];
  logic [3:0]       ford_mem [UnitCount];

  logic [LinkW-1:0] list_head [TopOrder+1];

  state_t state, state_next;
  logic [47:0] region_base;

  // Working registers.
  cmd_t        cmd;
  logic [31:0] size;
  logic [47:0] addr;
  logic [3:0]  want;
  logic [3:0]  lvl;
  logic [PageW-1:0] page;
  logic [PageW-1:0] bud;
  logic [PageW-1:0] clr;
  state_t      ret;       // state to resume after an unlink
  logic [PageW-1:0] unl_pg;
  logic [3:0]  unl_ord;
  logic [LinkW-1:0] unl_p, unl_n;

  // Memory port control.
  logic [PageW-1:0] rd_addr;
  logic [LinkW-1:0] rd_next, rd_prev;
  logic [3:0]       rd_aord, rd_ford;

  // Size to order: ceil log2 of size, in pages.
  logic [5:0] s_log;
  always_comb begin
    s_log = 6'd0;
    for (int k = 0; k <= 31; k++) begin
      if (size[k]) s_log = 6'(k);
    end
    // s_log = index of top set bit; bump unless exact power of two
    if (size == 32'd0) s_log = 6'd0;
    else if ((size & (size - 32'd1)) != 32'd0) s_log = s_log + 6'd1;
  end
  logic [5:0] want_w;
  assign want_w = (s_log <= 6'(PageShift)) ? 6'd0 : s_log - 6'(PageShift);

  // Address to page.
  logic [47:0] off;
  logic        in_range;
  assign off = addr - region_base;
  assign in_range = (addr >= region_base) && (off[47:PageShift] < 36'(UnitCount));
  logic [PageW-1:0] addr_pg;
  assign addr_pg = off[PageShift+PageW-1:PageShift];

  logic [3:0] lvm1;
  assign lvm1 = lvl - 4'd1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (start && !done) state_next = S_DECODE;
      S_CLEAR:      if (clr == PageW'(UnitCount-1)) state_next = S_IDLE;
      S_DECODE: begin
        unique case (cmd)
          CMD_ALLOC: state_next = (want_w > 6'(TopOrder)) ? S_DONE : S_FIND;
          CMD_FREE:  state_next = in_range ? S_FREE_RD : S_DONE;
          CMD_CHECK: state_next = in_range ? S_CHECK_RD : S_DONE;
          default:   state_next = S_DONE;
        endcase
      end
      S_FIND: begin
        if (list_head[lvl] != Nil) state_next = (lvl == want) ? S_TAKE_RD : S_SPLIT_RD;
        else if (lvl == 4'(TopOrder)) state_next = S_DONE;
      end
      S_SPLIT_RD:   state_next = S_SPLIT_WAIT;
      S_SPLIT_WAIT: state_next = S_UNL_P;
      S_PUSH_B:     state_next = S_PUSH_N;
      S_PUSH_N:     state_next = (lvm1 == want) ? S_TAKE_RD : S_SPLIT_RD;
      S_TAKE_RD:    state_next = S_TAKE_WAIT;
      S_TAKE_WAIT:  state_next = S_UNL_P;
      S_TAKE_FIN:   state_next = S_DONE;
      S_FREE_RD:    state_next = S_FREE_WAIT;
      S_FREE_WAIT:  state_next = (rd_aord > 4'(TopOrder)) ? S_DONE : S_FREE_BUD;
      S_FREE_BUD:   state_next = (lvl < 4'(TopOrder)) ? S_FREE_BWAIT : S_FREE_PUSH;
      S_FREE_BWAIT: state_next = (rd_ford == lvl) ? S_UNL_P : S_FREE_PUSH;
      S_FREE_UNL:   state_next = S_FREE_BUD;
      S_FREE_PUSH:  state_next = S_DONE;
      S_CHECK_RD:   state_next = S_CHECK_WAIT;
      S_CHECK_WAIT: state_next = S_DONE;
      S_UNL_P:      state_next = S_UNL_N;
      S_UNL_N:      state_next = ret;
      S_DONE:       state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Read address selection for the page stores.
  always_comb begin
    unique case (state) inside
      S_SPLIT_RD, S_TAKE_RD: rd_addr = list_head[lvl][PageW-1:0];
      S_FREE_BUD:            rd_addr = page ^ PageW'(1 << lvl);
      default:               rd_addr = page;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_next <= next_mem[rd_addr];
    rd_prev <= prev_mem[rd_addr];
    rd_aord <= aord_mem[rd_addr];
    rd_ford <= ford_mem[rd_addr];
  end

  // Store writes: one page per cycle per store.
  logic             we_n, we_p, we_a, we_f;
  logic [PageW-1:0] wa_n, wa_p, wa_a, wa_f;
  logic [LinkW-1:0] wd_n, wd_p;
  logic [3:0]       wd_a, wd_f;
  logic [LinkW-1:0] old_head;
  logic [PageW-1:0] push_pg;
  logic [3:0]       push_ord;

  always_comb begin
    we_n = 1'b0; we_p = 1'b0; we_a = 1'b0; we_f = 1'b0;
    wa_n = page; wa_p = page; wa_a = page; wa_f = page;
    wd_n = Nil; wd_p = Nil; wd_a = OrdNone; wd_f = OrdNone;
    push_pg = page;
    push_ord = lvl;
    unique case (state)
      S_PUSH_B:    begin push_pg = bud;  push_ord = lvm1; end
      S_PUSH_N:    begin push_pg = page; push_ord = lvm1; end
      default:     ;
    endcase
    old_head = list_head[push_ord];
    unique case (state) inside
      S_CLEAR: begin
        we_n = 1'b1; we_p = 1'b1; we_a = 1'b1; we_f = 1'b1;
        wa_n = clr; wa_p = clr; wa_a = clr; wa_f = clr;
        wd_f = (clr == '0) ? 4'(TopOrder) : OrdNone;
      end
      S_PUSH_B, S_PUSH_N, S_FREE_PUSH: begin
        // push: next = old head, order mark; back-link old head, or prev = nil if empty
        we_n = 1'b1; wa_n = push_pg; wd_n = old_head;
        we_f = 1'b1; wa_f = push_pg; wd_f = push_ord;
        we_p = 1'b1;
        if (old_head != Nil) begin
          wa_p = old_head[PageW-1:0]; wd_p = LinkW'(push_pg);
        end else begin
          wa_p = push_pg; wd_p = Nil;
        end
      end
      S_UNL_P: begin
        // fix the neighbors, clear this page's order mark
        if (unl_p != Nil) begin
          we_n = 1'b1; wa_n = unl_p[PageW-1:0]; wd_n = unl_n;
        end
        if (unl_n != Nil) begin
          we_p = 1'b1; wa_p = unl_n[PageW-1:0]; wd_p = unl_p;
        end
        we_f = 1'b1; wa_f = unl_pg; wd_f = OrdNone;
      end
      S_UNL_N: begin
        we_n = 1'b1; wa_n = unl_pg; wd_n = Nil;
        we_p = 1'b1; wa_p = unl_pg; wd_p = Nil;
      end
      S_TAKE_FIN: begin
        we_a = 1'b1; wa_a = page; wd_a = want;
      end
      S_FREE_WAIT: begin
        if (rd_aord <= 4'(TopOrder)) begin
          we_a = 1'b1; wa_a = page; wd_a = OrdNone;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_n) next_mem[wa_n] <= wd_n;
    if (we_p) prev_mem[wa_p] <= wd_p;
    if (we_a) aord_mem[wa_a] <= wd_a;
    if (we_f) ford_mem[wa_f] <= wd_f;
  end

  // Control and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      region_base <= '0;
      done <= 1'b0;
      for (int k = 0; k <= TopOrder; k++) begin
        list_head[k] <= (k == TopOrder) ? LinkW'(0) : Nil;
      end
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_we) region_base <= cfg_wdata;
      unique case (state) inside
        S_CLEAR: clr <= clr + PageW'(1);
        S_IDLE: if (start && !done) begin
          cmd <= cmd_t'(command);
          size <= request_size;
          addr <= block_address;
        end
        S_DECODE: begin
          status <= ST_OK;
          result_address <= '0;
          is_allocated <= 1'b0;
          want <= want_w[3:0];
          lvl <= want_w[3:0];
          page <= addr_pg;
          unique case (cmd) inside
            CMD_ALLOC: if (want_w > 6'(TopOrder)) status <= ST_NOSPACE;
            CMD_FREE, CMD_CHECK: if (!in_range) status <= ST_RANGE;
            default: ;
          endcase
        end
        S_FIND: begin
          if (list_head[lvl] == Nil) begin
            if (lvl == 4'(TopOrder)) status <= ST_NOSPACE;
            else lvl <= lvl + 4'd1;
          end
        end
        S_SPLIT_RD, S_TAKE_RD: page <= list_head[lvl][PageW-1:0];
        S_SPLIT_WAIT, S_TAKE_WAIT, S_FREE_BWAIT: begin
          unl_pg <= (state == S_FREE_BWAIT) ? bud : page;
          unl_ord <= lvl;
          unl_p <= rd_prev;
          unl_n <= rd_next;
          ret <= (state == S_SPLIT_WAIT) ? S_PUSH_B :
                 (state == S_TAKE_WAIT) ? S_TAKE_FIN : S_FREE_UNL;
          bud <= page ^ PageW'(1 << lvm1);
        end
        S_UNL_P: if (unl_p == Nil) list_head[unl_ord] <= unl_n;
        S_PUSH_B, S_PUSH_N, S_FREE_PUSH: list_head[push_ord] <= LinkW'(push_pg);
        S_TAKE_FIN:
          result_address <= region_base + (48'(page) << PageShift);
        S_FREE_WAIT: begin
          if (rd_aord > 4'(TopOrder)) status <= ST_NOTALLOC;
          lvl <= rd_aord;
        end
        S_FREE_BUD: bud <= page ^ PageW'(1 << lvl);
        S_FREE_UNL: begin
          page <= page & ~PageW'(1 << lvl);
          lvl <= lvl + 4'd1;
        end
        S_CHECK_WAIT: is_allocated <= (rd_aord != OrdNone);
        S_DONE: done <= 1'b1;
        default: ;
      endcase
      // After pushing the lower half, descend one level.
      if (state == S_PUSH_N) lvl <= lvm1;
    end
  end

  // done rises the cycle after S_DONE; busy covers that cycle too.
  assign busy = (state != S_IDLE) || done;

endmodule

// ===== design/bpa_checker.sv =====
// Checker: port-level properties of the buddy page allocator.
module bpa_checker
  import bpa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [47:0] result_address,
  input logic        is_allocated
);
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done outside busy");
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> result_address == 48'd0)
    else $error("address on failure");
  a_alloc_flag: assert property (@(posedge clk) disable iff (rst)
    done && is_allocated |-> status == ST_OK) else $error("flag with error");
  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("transaction not taken");
endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .result_address(result_address), .is_allocated(is_allocated)
);

// ===== verif/tb_buddy_page_allocator.sv =====
// Testbench for the buddy page allocator: directed and random commands checked against a predictor.
import bpa_pkg::*;

class alloc_scoreboard;
  // predictor state
  logic [47:0] base;
  int unsigned head [TopOrder+1];
  int unsigned nxt [UnitCount];
  int unsigned prv [UnitCount];
  int unsigned aord [UnitCount];
  int unsigned ford [UnitCount];
  // pending results
  logic [1:0]  exp_status [$];
  logic [47:0] exp_addr [$];
  logic        exp_alloc [$];
  int errors;
  // live allocations, page addresses for random frees
  logic [47:0] live [$];

  function new();
    base = '0;
    errors = 0;
    for (int i = 0; i <= TopOrder; i++) head[i] = UnitCount;
    for (int i = 0; i < UnitCount; i++) begin
      nxt[i] = UnitCount; prv[i] = UnitCount;
      aord[i] = 255; ford[i] = 255;
    end
    push(TopOrder, 0);
  endfunction

  function void push(int unsigned ord, int unsigned pg);
    int unsigned old;
    old = head[ord];
    nxt[pg] = old;
    prv[pg] = UnitCount;
    if (old < UnitCount) prv[old] = pg;
    head[ord] = pg;
    ford[pg] = ord;
  endfunction

  function void unlink(int unsigned ord, int unsigned pg);
    int unsigned p, n;
    p = prv[pg];
    n = nxt[pg];
    if (p < UnitCount) nxt[p] = n;
    else head[ord] = n;
    if (n < UnitCount) prv[n] = p;
    nxt[pg] = UnitCount; prv[pg] = UnitCount; ford[pg] = 255;
  endfunction

  function bit page_of(logic [47:0] a, output int unsigned pg);
    logic [47:0] off;
    pg = 0;
    if (a < base) return 0;
    off = (a - base) >> PageShift;
    if (off >= UnitCount) return 0;
    pg = 32'(off);
    return 1;
  endfunction

  // note an accepted command and queue its expected result
  function void note_command(cmd_t cmd, logic [31:0] size, logic [47:0] a);
    logic [1:0] st;
    logic [47:0] ra;
    logic ia;
    int unsigned pg, s, want, i, b;
    st = ST_OK; ra = '0; ia = 0;
    case (cmd)
      CMD_ALLOC: begin
        s = 0;
        while (s < 40 && (64'd1 << s) < {32'd0, size}) s++;
        want = (s <= PageShift) ? 0 : s - PageShift;
        if (want > TopOrder) st = ST_NOSPACE;
        else begin
          for (i = want; i <= TopOrder; i++) if (head[i] < UnitCount) break;
          if (i > TopOrder) st = ST_NOSPACE;
          else begin
            for (; i > want; i--) begin
              pg = head[i];
              b = (pg ^ (1 << (i - 1))) % UnitCount;
              unlink(i, pg);
              push(i - 1, b);
              push(i - 1, pg);
            end
            pg = head[want];
            unlink(want, pg);
            aord[pg] = want;
            ra = base + (48'(pg) << PageShift);
            live.push_back(ra);
          end
        end
      end
      CMD_FREE: begin
        if (!page_of(a, pg)) st = ST_RANGE;
        else if (aord[pg] > TopOrder) st = ST_NOTALLOC;
        else begin
          i = aord[pg];
          aord[pg] = 255;
          while (i < TopOrder) begin
            b = (pg ^ (1 << i)) % UnitCount;
            if (ford[b] != i) break;
            unlink(i, b);
            pg &= ~(1 << i);
            i++;
          end
          push(i, pg);
        end
      end
      CMD_CHECK: begin
        if (!page_of(a, pg)) st = ST_RANGE;
        else ia = (aord[pg] != 255);
      end
      default: ;
    endcase
    exp_status.push_back(st);
    exp_addr.push_back(ra);
    exp_alloc.push_back(ia);
  endfunction

  task report(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  task check_result(logic [1:0] st, logic [47:0] ra, logic ia);
    if (exp_status.size() == 0) begin
      report("result with nothing pending");
      return;
    end
    if (st !== exp_status[0])
      report($sformatf("status got %0d want %0d", st, exp_status[0]));
    if (ra !== exp_addr[0])
      report($sformatf("address got %h want %h", ra, exp_addr[0]));
    if (ia !== exp_alloc[0])
      report($sformatf("is_allocated got %0d want %0d", ia, exp_alloc[0]));
    void'(exp_status.pop_front());
    void'(exp_addr.pop_front());
    void'(exp_alloc.pop_front());
  endtask
endclass

module tb_buddy_page_allocator;
  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  command = '0;
  logic [31:0] request_size = '0;
  logic [47:0] block_address = '0;
  logic        cfg_we = 0;
  logic [47:0] cfg_wdata = '0;
  logic        done;
  logic [1:0]  status;
  logic [47:0] result_address;
  logic        is_allocated;

  alloc_scoreboard sb = new();
  bit calm;   // suppress random idling during the quiet stretch

  buddy_page_allocator i_dut (
    .clk, .rst, .start, .busy, .command, .request_size, .block_address,
    .cfg_we, .cfg_wdata, .done, .status, .result_address, .is_allocated
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Sample each result strobe at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, result_address, is_allocated);
  end

  // Drive one transaction; hold start until the block takes it. start stays
  // high after the handoff and drops when the sender idles or drains.
  task send(cmd_t cmd, logic [31:0] size, logic [47:0] a);
    while (!calm && $urandom_range(99) < 29) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    command <= cmd;
    request_size <= size;
    block_address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(cmd, size, a);
  endtask

  // Wait for every pending result, then let the block settle.
  task drain();
    start <= 0;
    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task set_base(logic [47:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.base = v;
  endtask

  // Pick an address near the region: mostly live blocks, some strays.
  function logic [47:0] pick_addr();
    int r;
    r = $urandom_range(99);
    if (r < 60 && sb.live.size() != 0)
      return sb.live[$urandom_range(sb.live.size() - 1)] + 48'($urandom_range(4095) * (r & 1));
    if (r < 90) return sb.base + 48'($urandom_range(UnitCount * 4096 - 1));
    return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
  endfunction

  function logic [31:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(8 * 4096);
    if (r < 95) return $urandom_range(4096 << 10);
    return $urandom;
  endfunction

  task random_phase(int n);
    int r, idx;
    logic [47:0] a;
    for (int k = 0; k < n; k++) begin
      calm = (k > n / 3 && k < n / 2);
      r = $urandom_range(99);
      if (r < 40) send(CMD_ALLOC, pick_size(), '0);
      else if (r < 75) begin
        a = pick_addr();
        idx = -1;
        foreach (sb.live[j]) if (sb.live[j] == a) idx = j;
        if (idx >= 0) sb.live.delete(idx);
        send(CMD_FREE, $urandom, a);
      end else if (r < 97) send(CMD_CHECK, $urandom, pick_addr());
      else send(CMD_NOP, $urandom, {$urandom, $urandom});
      if (k == n / 4) drain();   // sender pause until all results are back
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extremes, every command, the special cases.
    send(CMD_ALLOC, 32'd0, '0);                // zero size takes one page
    send(CMD_ALLOC, 32'd4097, '0);             // rounds to two pages
    send(CMD_ALLOC, 32'hFFFF_FFFF, '0);        // larger than region
    send(CMD_ALLOC, 32'd4096 << 10, '0);       // whole region, no room now
    send(CMD_CHECK, '0, 48'd0);
    send(CMD_CHECK, '0, 48'd4095);             // unaligned offset dropped
    send(CMD_CHECK, '0, 48'd12288);            // second page of a two-page block
    send(CMD_CHECK, '0, 48'hFFFF_FFFF_FFFF);   // outside region
    send(CMD_FREE, '0, 48'd12288);             // not a block's first page
    send(CMD_FREE, '0, 48'd4096 * 1024);       // one page past the end
    send(CMD_FREE, '0, 48'd4);                 // free first page, unaligned
    send(CMD_FREE, '0, 48'd8192);              // merge back to top
    send(CMD_ALLOC, 32'd4096 << 10, '0);       // whole region fits
    send(CMD_FREE, '0, 48'd0);
    send(CMD_NOP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    sb.live.delete();
    set_base(48'hFFFF_FFFF_FFFF);              // address wrap
    send(CMD_ALLOC, 32'd1, '0);
    send(CMD_CHECK, '0, 48'h0);                // below base
    send(CMD_FREE, '0, 48'hFFFF_FFFF_FFFF);
    set_base(48'h0000_1234_5000);
    random_phase(700);
    set_base({$urandom, $urandom} & 48'hFFFF_FFFF_F000);
    random_phase(350);
    set_base(48'd0);
    random_phase(350);
    drain();
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== buddy_page_allocator.f =====
design/bpa_pkg.sv
design/buddy_page_allocator.sv
design/bpa_checker.sv
verif/tb_buddy_page_allocator.sv
